[hdl/psbb_pkg.sv]
// psbb_pkg: shared types, constants and codes for the band-power binner
// depends on nothing; imported by every module of the block

package psbb_pkg;

    // default sizes of the stores
    localparam int DEF_MAX_ELL     = 4096;
    localparam int DEF_MAX_BANDS   = 256;
    localparam int DEF_MAX_SPECTRA = 4;

    // field widths fixed by the interface
    localparam int KIND_W  = 2;
    localparam int ELL_IN_W = 12;
    localparam int BAND_IN_W = 9;
    localparam int DATA_W  = 32;
    localparam int COMP_W  = 2;
    localparam int EFF_W   = 28;
    localparam int CFG_W   = 12;
    localparam int NSPEC_W = 3;
    localparam int SUM_W   = 48;
    localparam int ACC_DW  = 64;

    // Q16.16 one
    localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sh0001_0000;

    // quotient caps
    localparam logic [DATA_W-1:0] CAP_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] CAP_NEG = 32'h8000_0000;
    localparam logic [DATA_W-1:0] CAP_EFF = 32'h0FFF_FFFF;

    // configuration register indexes
    localparam logic REG_ELL_MAX     = 1'b0;
    localparam logic REG_NUM_SPECTRA = 1'b1;

    // reset values of the configuration registers
    localparam logic [ELL_IN_W-1:0] ELL_MAX_RST = 12'd4095;
    localparam logic [NSPEC_W-1:0]  NSPEC_RST   = 3'd1;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // classified request, as held in the queue
    typedef struct packed {
        op_t                        op;
        logic [ELL_IN_W-1:0]        ell;
        logic signed [BAND_IN_W-1:0] band;
        logic signed [DATA_W-1:0]   weight;
        logic signed [DATA_W-1:0]   factor;
        logic [COMP_W-1:0]          comp;
        logic signed [DATA_W-1:0]   value;
        logic                       load_ok;
        logic                       ell_in;
        logic                       band_ok;
        logic                       comp_ok;
    } req_t;

    // back-end sequencer states
    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_L1,
        ST_L2,
        ST_S1,
        ST_S2,
        ST_S3,
        ST_S4,
        ST_R1,
        ST_RDA,
        ST_RDE
    } st_t;

endpackage

[hdl/power_spectrum_band_binner_top.sv]
// power_spectrum_band_binner_top: weighted band-power binner, Q16.16
// depends on psbb_pkg, psbb_front, psbb_div, psbb_back
//
// channel  dir  handshake            payload
// in       in   in_valid / in_stall  kind ell band weight ell_factor component value
// out      out  out_valid/ out_stall binned_value effective_ell bad_weight saturated
// cfg      in   cfg_write            cfg_index cfg_data
//
// load passes states L1 and L2, sample S1 to S4, read up to two serial divisions
// clear sweeps every entry of the largest store (4096 at default sizes)
// after reset the same clearing pass runs first; in_stall is high meanwhile
// a two-entry queue keeps taking requests, until full, while the back end works or out_stall holds

module power_spectrum_band_binner_top
    import psbb_pkg::*;
#(
    parameter int MAX_ELL     = DEF_MAX_ELL,
    parameter int MAX_BANDS   = DEF_MAX_BANDS,
    parameter int MAX_SPECTRA = DEF_MAX_SPECTRA
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic                         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [KIND_W-1:0]            kind,
    input  logic [ELL_IN_W-1:0]          ell,
    input  logic signed [BAND_IN_W-1:0]  band,
    input  logic signed [DATA_W-1:0]     weight,
    input  logic signed [DATA_W-1:0]     ell_factor,
    input  logic [COMP_W-1:0]            component,
    input  logic signed [DATA_W-1:0]     value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_W-1:0]     binned_value,
    output logic [EFF_W-1:0]             effective_ell,
    output logic                         bad_weight,
    output logic                         saturated
);

    req_t              head;
    logic              head_valid, pop, sweeping;
    logic              div_start, div_busy, div_done, div_over;
    logic [ACC_DW-1:0] div_mag;
    logic [SUM_W-1:0]  div_den;
    logic [DATA_W-1:0] div_cap, div_q;

    // request intake and queue
    psbb_front #(
        .MAX_ELL     (MAX_ELL),
        .MAX_BANDS   (MAX_BANDS),
        .MAX_SPECTRA (MAX_SPECTRA)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .ell        (ell),
        .band       (band),
        .weight     (weight),
        .ell_factor (ell_factor),
        .component  (component),
        .value      (value),
        .sweeping   (sweeping),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // serial divider
    psbb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (div_mag),
        .den   (div_den),
        .cap   (div_cap),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_q),
        .over  (div_over)
    );

    // store sequencer and result register
    psbb_back #(
        .MAX_ELL     (MAX_ELL),
        .MAX_BANDS   (MAX_BANDS),
        .MAX_SPECTRA (MAX_SPECTRA)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .sweeping      (sweeping),
        .div_start     (div_start),
        .div_mag       (div_mag),
        .div_den       (div_den),
        .div_cap       (div_cap),
        .div_busy      (div_busy),
        .div_done      (div_done),
        .div_q         (div_q),
        .div_over      (div_over),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .binned_value  (binned_value),
        .effective_ell (effective_ell),
        .bad_weight    (bad_weight),
        .saturated     (saturated)
    );

endmodule

[hdl/psbb_front.sv]
// psbb_front: configuration registers, request classification, two-entry queue
// depends on psbb_pkg

module psbb_front
    import psbb_pkg::*;
#(
    parameter int MAX_ELL     = DEF_MAX_ELL,
    parameter int MAX_BANDS   = DEF_MAX_BANDS,
    parameter int MAX_SPECTRA = DEF_MAX_SPECTRA
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic                         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [KIND_W-1:0]            kind,
    input  logic [ELL_IN_W-1:0]          ell,
    input  logic signed [BAND_IN_W-1:0]  band,
    input  logic signed [DATA_W-1:0]     weight,
    input  logic signed [DATA_W-1:0]     ell_factor,
    input  logic [COMP_W-1:0]            component,
    input  logic signed [DATA_W-1:0]     value,
    input  logic                         sweeping,
    input  logic                         pop,
    output logic                         head_valid,
    output req_t                         head
);

    logic [ELL_IN_W-1:0] ell_max_reg;
    logic [NSPEC_W-1:0]  num_spectra_reg;
    logic [31:0]         ns_clamped;
    req_t                req_new;
    req_t                queue_mem [2];
    logic                wr_ptr_reg, rd_ptr_reg;
    logic [1:0]          count_reg, count_next;
    logic                push;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ell_max_reg     <= ELL_MAX_RST;
            num_spectra_reg <= NSPEC_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ELL_MAX:     ell_max_reg     <= cfg_data;
                REG_NUM_SPECTRA: num_spectra_reg <= cfg_data[NSPEC_W-1:0];
                default:         ell_max_reg     <= ell_max_reg;
            endcase
        end
    end

    // component count held to 1..MAX_SPECTRA
    always_comb
    begin
        if (num_spectra_reg == '0)
            ns_clamped = 32'd1;
        else if (32'(num_spectra_reg) > 32'(MAX_SPECTRA))
            ns_clamped = 32'(MAX_SPECTRA);
        else
            ns_clamped = 32'(num_spectra_reg);
    end

    // classify the incoming request
    always_comb
    begin
        req_new.op      = op_t'(kind);
        req_new.ell     = ell;
        req_new.band    = band;
        req_new.weight  = weight;
        req_new.factor  = (ell_factor[DATA_W-1] || ell_factor == '0) ? ONE_Q16 : ell_factor;
        req_new.comp    = component;
        req_new.value   = value;
        req_new.ell_in  = 32'(ell) < 32'(MAX_ELL);
        req_new.band_ok = !band[BAND_IN_W-1] && (32'(band[BAND_IN_W-2:0]) < 32'(MAX_BANDS));
        req_new.comp_ok = 32'(component) < ns_clamped;
        req_new.load_ok = (ell <= ell_max_reg) && req_new.ell_in && req_new.band_ok;
    end

    // queue between front and back
    assign in_stall   = (count_reg == 2'd2) || sweeping;
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != 2'd0);
    assign head       = queue_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_mem[wr_ptr_reg] <= req_new;
    end

endmodule

[hdl/psbb_div.sv]
// psbb_div: bit-serial scaled divider, floor(mag * 2^16 / den) capped
// depends on psbb_pkg

module psbb_div
    import psbb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ACC_DW-1:0]   mag,
    input  logic [SUM_W-1:0]    den,
    input  logic [DATA_W-1:0]   cap,
    output logic                busy,
    output logic                done,
    output logic [DATA_W-1:0]   quot,
    output logic                over
);

    localparam int STEPS = ACC_DW + 16;

    logic              busy_reg, done_reg, over_reg;
    logic [6:0]        cnt_reg;
    logic [STEPS-1:0]  dvd_reg;
    logic [SUM_W-1:0]  rem_reg, den_reg;
    logic [DATA_W-1:0] q_reg, cap_reg;
    logic [SUM_W:0]    rem_sh, rem_sub;
    logic              ge;
    logic [DATA_W:0]   q_new;

    // one quotient bit per cycle
    assign rem_sh  = {rem_reg, dvd_reg[STEPS-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign q_new   = {q_reg, ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= {mag, 16'b0};
            den_reg  <= den;
            cap_reg  <= cap;
            rem_reg  <= '0;
            q_reg    <= '0;
            over_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[STEPS-2:0], 1'b0};
            rem_reg <= ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
            if (!over_reg)
            begin
                if (q_new > {1'b0, cap_reg})
                    over_reg <= 1'b1;
                else
                    q_reg <= q_new[DATA_W-1:0];
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = over_reg ? cap_reg : q_reg;
    assign over = over_reg;

endmodule

[hdl/psbb_back.sv]
// psbb_back: sequencer over the ell tables, band sums and accumulators
// depends on psbb_pkg; works with psbb_div

module psbb_back
    import psbb_pkg::*;
#(
    parameter int MAX_ELL     = DEF_MAX_ELL,
    parameter int MAX_BANDS   = DEF_MAX_BANDS,
    parameter int MAX_SPECTRA = DEF_MAX_SPECTRA
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    input  req_t                      head,
    output logic                      pop,
    output logic                      sweeping,
    output logic                      div_start,
    output logic [ACC_DW-1:0]         div_mag,
    output logic [SUM_W-1:0]          div_den,
    output logic [DATA_W-1:0]         div_cap,
    input  logic                      div_busy,
    input  logic                      div_done,
    input  logic [DATA_W-1:0]         div_q,
    input  logic                      div_over,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DATA_W-1:0]  binned_value,
    output logic [EFF_W-1:0]          effective_ell,
    output logic                      bad_weight,
    output logic                      saturated
);

    localparam int ELL_W  = $clog2(MAX_ELL);
    localparam int BAND_W = $clog2(MAX_BANDS);
    localparam int NACC   = MAX_BANDS * MAX_SPECTRA;
    localparam int ACC_W  = $clog2(NACC);
    localparam int SWEEP  = (MAX_ELL > NACC) ? MAX_ELL : NACC;
    localparam int SW_W   = $clog2(SWEEP);

    // saturating adds
    function automatic logic [SUM_W:0] add48(input logic [SUM_W-1:0] a,
                                             input logic [SUM_W-1:0] t);
        logic [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {t[SUM_W-1], t};
        if (s[SUM_W] != s[SUM_W-1])
            return {1'b1, s[SUM_W], {(SUM_W-1){!s[SUM_W]}}};
        return {1'b0, s[SUM_W-1:0]};
    endfunction

    function automatic logic [ACC_DW:0] add64(input logic [ACC_DW-1:0] a,
                                              input logic [ACC_DW-1:0] t);
        logic [ACC_DW:0] s;
        s = {a[ACC_DW-1], a} + {t[ACC_DW-1], t};
        if (s[ACC_DW] != s[ACC_DW-1])
            return {1'b1, s[ACC_DW], {(ACC_DW-1){!s[ACC_DW]}}};
        return {1'b0, s[ACC_DW-1:0]};
    endfunction

    // stores
    logic [BAND_W:0]           map_mem  [MAX_ELL];
    logic signed [DATA_W-1:0]  wt_mem   [MAX_ELL];
    logic signed [DATA_W-1:0]  ft_mem   [MAX_ELL];
    logic [SUM_W-1:0]          wsum_mem [MAX_BANDS];
    logic [SUM_W-1:0]          esum_mem [MAX_BANDS];
    logic [ACC_DW-1:0]         acc_mem  [NACC];

    logic [BAND_W:0]           map_q;
    logic signed [DATA_W-1:0]  wt_q, ft_q;
    logic [SUM_W-1:0]          wsum_q, esum_q;
    logic [ACC_DW-1:0]         acc_q;

    // state
    st_t                       state_reg, state_next;
    logic [SW_W-1:0]           cnt_reg, cnt_next;
    logic                      clr_res_reg, clr_res_next;
    req_t                      cur_reg, cur_next;
    logic signed [ACC_DW-1:0]  prod_reg, prod_next;
    logic signed [DATA_W-1:0]  wf_reg, wf_next;
    logic [ACC_W-1:0]          acc_idx_reg, acc_idx_next;
    logic [SUM_W-1:0]          wsum_new_reg, wsum_new_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]  binned_reg, binned_next;
    logic [EFF_W-1:0]          eff_reg, eff_next;
    logic                      bad_reg, bad_next;
    logic                      sat_reg, sat_next;

    // memory ports
    logic                      rd_ell, rd_band, rd_acc;
    logic [ELL_W-1:0]          ell_ra, ell_wa;
    logic [BAND_W-1:0]         band_ra, band_wa;
    logic [ACC_W-1:0]          acc_ra, acc_wa;
    logic                      map_we, tbl_we, sum_we, acc_we;
    logic [BAND_W:0]           map_wd;
    logic [SUM_W-1:0]          wsum_wd, esum_wd;
    logic [ACC_DW-1:0]         acc_wd;

    // helpers
    logic [31:0]               head_ell_w, head_band_w, cur_ell_w, cur_band_w;
    logic [31:0]               head_acc_w, map_acc_w;
    logic [SUM_W:0]            add_s;
    logic [ACC_DW:0]           add_a;
    logic signed [ACC_DW-1:0]  shifted;
    logic                      ws_pos;
    logic                      sweep_last;

    assign head_ell_w  = 32'(head.ell);
    assign head_band_w = 32'(head.band[BAND_IN_W-2:0]);
    assign cur_ell_w   = 32'(cur_reg.ell);
    assign cur_band_w  = 32'(cur_reg.band[BAND_IN_W-2:0]);
    assign head_acc_w  = 32'(head_band_w[BAND_W-1:0]) * 32'(MAX_SPECTRA) + 32'(head.comp);
    assign map_acc_w   = 32'(map_q[BAND_W-1:0]) * 32'(MAX_SPECTRA) + 32'(cur_reg.comp);
    assign ws_pos      = cur_reg.band_ok && !wsum_q[SUM_W-1] && (wsum_q != '0);
    assign sweep_last  = (cnt_reg == SW_W'(SWEEP - 1));
    assign sweeping    = (state_reg == ST_SWEEP);

    // next state and outputs of the sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        clr_res_next   = clr_res_reg;
        cur_next       = cur_reg;
        prod_next      = prod_reg;
        wf_next        = wf_reg;
        acc_idx_next   = acc_idx_reg;
        wsum_new_next  = wsum_new_reg;
        out_valid_next = out_valid_reg && out_stall;
        binned_next    = binned_reg;
        eff_next       = eff_reg;
        bad_next       = bad_reg;
        sat_next       = sat_reg;
        pop            = 1'b0;
        div_start      = 1'b0;
        div_mag        = '0;
        div_den        = wsum_q;
        div_cap        = CAP_EFF;
        rd_ell         = 1'b0;
        rd_band        = 1'b0;
        rd_acc         = 1'b0;
        ell_ra         = head_ell_w[ELL_W-1:0];
        band_ra        = head_band_w[BAND_W-1:0];
        acc_ra         = head_acc_w[ACC_W-1:0];
        map_we         = 1'b0;
        tbl_we         = 1'b0;
        sum_we         = 1'b0;
        acc_we         = 1'b0;
        ell_wa         = cur_ell_w[ELL_W-1:0];
        band_wa        = cur_band_w[BAND_W-1:0];
        acc_wa         = acc_idx_reg;
        map_wd         = {1'b1, cur_band_w[BAND_W-1:0]};
        wsum_wd        = wsum_new_reg;
        esum_wd        = '0;
        acc_wd         = '0;
        add_s          = '0;
        add_a          = '0;
        shifted        = '0;

        case (state_reg)
            // clear every store, one address a cycle
            ST_SWEEP:
            begin
                ell_wa  = cnt_reg[ELL_W-1:0];
                band_wa = cnt_reg[BAND_W-1:0];
                acc_wa  = cnt_reg[ACC_W-1:0];
                map_wd  = '0;
                wsum_wd = '0;
                map_we  = 32'(cnt_reg) < 32'(MAX_ELL);
                sum_we  = 32'(cnt_reg) < 32'(MAX_BANDS);
                acc_we  = 32'(cnt_reg) < 32'(NACC);
                if (sweep_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                    if (clr_res_reg)
                    begin
                        out_valid_next = 1'b1;
                        clr_res_next   = 1'b0;
                    end
                end
                else
                    cnt_next = cnt_reg + SW_W'(1);
            end

            // take the next request and start the reads
            ST_IDLE:
            begin
                if (head_valid && !out_valid_reg)
                begin
                    pop         = 1'b1;
                    cur_next    = head;
                    rd_ell      = 1'b1;
                    rd_band     = 1'b1;
                    rd_acc      = 1'b1;
                    binned_next = '0;
                    eff_next    = '0;
                    bad_next    = 1'b0;
                    sat_next    = 1'b0;
                    case (head.op)
                        OP_LOAD:   state_next = ST_L1;
                        OP_SAMPLE: state_next = ST_S1;
                        OP_READ:   state_next = ST_R1;
                        OP_CLEAR:
                        begin
                            state_next   = ST_SWEEP;
                            clr_res_next = 1'b1;
                        end
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end

            // load: assign the ell, add the weight
            ST_L1:
            begin
                if (cur_reg.load_ok && !map_q[BAND_W])
                begin
                    map_we        = 1'b1;
                    tbl_we        = 1'b1;
                    prod_next     = ACC_DW'($signed({1'b0, cur_reg.ell}))
                                    * ACC_DW'(cur_reg.weight);
                    add_s         = add48(wsum_q, SUM_W'(cur_reg.weight));
                    wsum_new_next = add_s[SUM_W-1:0];
                    sat_next      = add_s[SUM_W];
                    state_next    = ST_L2;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            // load: add ell times weight, write both sums
            ST_L2:
            begin
                add_s          = add48(esum_q, prod_reg[SUM_W-1:0]);
                esum_wd        = add_s[SUM_W-1:0];
                sum_we         = 1'b1;
                sat_next       = sat_reg || add_s[SUM_W];
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end

            // sample: weight times factor, fetch the accumulator
            ST_S1:
            begin
                if (cur_reg.ell_in && map_q[BAND_W] && cur_reg.comp_ok)
                begin
                    prod_next    = ACC_DW'(wt_q) * ACC_DW'(ft_q);
                    acc_idx_next = map_acc_w[ACC_W-1:0];
                    acc_ra       = map_acc_w[ACC_W-1:0];
                    rd_acc       = 1'b1;
                    state_next   = ST_S2;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            // sample: floor and clip to 32 bits
            ST_S2:
            begin
                shifted = prod_reg >>> 16;
                if (shifted[ACC_DW-1:DATA_W-1] != '0 && shifted[ACC_DW-1:DATA_W-1] != '1)
                begin
                    wf_next  = shifted[ACC_DW-1] ? CAP_NEG : CAP_POS;
                    sat_next = 1'b1;
                end
                else
                    wf_next = shifted[DATA_W-1:0];
                state_next = ST_S3;
            end

            // sample: times the value
            ST_S3:
            begin
                prod_next  = ACC_DW'(wf_reg) * ACC_DW'(cur_reg.value);
                state_next = ST_S4;
            end

            // sample: accumulate
            ST_S4:
            begin
                shifted        = prod_reg >>> 16;
                add_a          = add64(acc_q, shifted);
                acc_wd         = add_a[ACC_DW-1:0];
                acc_we         = 1'b1;
                sat_next       = sat_reg || add_a[ACC_DW];
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end

            // read: check the weight sum, start the first division
            ST_R1:
            begin
                if (!ws_pos)
                begin
                    bad_next       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (cur_reg.comp_ok)
                begin
                    div_start  = 1'b1;
                    div_mag    = acc_q[ACC_DW-1] ? (~acc_q + ACC_DW'(1)) : acc_q;
                    div_cap    = acc_q[ACC_DW-1] ? CAP_NEG : CAP_POS;
                    state_next = ST_RDA;
                end
                else if (esum_q[SUM_W-1])
                begin
                    sat_next       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_mag    = ACC_DW'(esum_q);
                    state_next = ST_RDE;
                end
            end

            // read: band power done, start effective ell unless its sum is negative
            ST_RDA:
            begin
                if (div_done)
                begin
                    binned_next = acc_q[ACC_DW-1] ? (~div_q + DATA_W'(1)) : div_q;
                    if (esum_q[SUM_W-1])
                    begin
                        sat_next       = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        sat_next   = sat_reg || div_over;
                        div_start  = 1'b1;
                        div_mag    = ACC_DW'(esum_q);
                        state_next = ST_RDE;
                    end
                end
            end

            // read: effective ell done
            ST_RDE:
            begin
                if (div_done)
                begin
                    eff_next       = div_q[EFF_W-1:0];
                    sat_next       = sat_reg || div_over;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            cnt_reg       <= '0;
            clr_res_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_res_reg   <= clr_res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        prod_reg     <= prod_next;
        wf_reg       <= wf_next;
        acc_idx_reg  <= acc_idx_next;
        wsum_new_reg <= wsum_new_next;
        binned_reg   <= binned_next;
        eff_reg      <= eff_next;
        bad_reg      <= bad_next;
        sat_reg      <= sat_next;
    end

    // ell map and tables
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[ell_wa] <= map_wd;
        if (tbl_we)
        begin
            wt_mem[ell_wa] <= cur_reg.weight;
            ft_mem[ell_wa] <= cur_reg.factor;
        end
        if (rd_ell)
        begin
            map_q <= map_mem[ell_ra];
            wt_q  <= wt_mem[ell_ra];
            ft_q  <= ft_mem[ell_ra];
        end
    end

    // band sums
    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            wsum_mem[band_wa] <= wsum_wd;
            esum_mem[band_wa] <= esum_wd;
        end
        if (rd_band)
        begin
            wsum_q <= wsum_mem[band_ra];
            esum_q <= esum_mem[band_ra];
        end
    end

    // band accumulators
    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[acc_wa] <= acc_wd;
        if (rd_acc)
            acc_q <= acc_mem[acc_ra];
    end

    assign out_valid     = out_valid_reg;
    assign binned_value  = binned_reg;
    assign effective_ell = eff_reg;
    assign bad_weight    = bad_reg;
    assign saturated     = sat_reg;

`ifndef SYNTHESIS
    // divider is never restarted mid-run
    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
        else $error("divider started while busy");

    // a bad weight sum reports zero values
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_reg) |-> (binned_reg == '0 && eff_reg == '0))
        else $error("bad weight with nonzero result");

    // the sweep ends in idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && sweep_last) |=> (state_reg == ST_IDLE))
        else $error("sweep did not end");

    // no request is taken while a result waits
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !out_valid_reg)
        else $error("request taken over a pending result");
`endif

endmodule

[test/tb_power_spectrum_band_binner_top.sv]
// testbench for the weighted band-power binner: directed and random requests
// against a behavioral predictor of the binning arithmetic
// depends on psbb_pkg and power_spectrum_band_binner_top
`timescale 1ns / 100ps

module tb_power_spectrum_band_binner_top;
    import psbb_pkg::*;

    localparam int N_ELL  = 4096;
    localparam int N_BAND = 256;
    localparam int N_SPEC = 4;
    localparam logic signed [47:0] S48_HI = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] S48_LO = 48'sh8000_0000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [KIND_W-1:0] kind = '0;
    logic [ELL_IN_W-1:0] ell = '0;
    logic signed [BAND_IN_W-1:0] band = '0;
    logic signed [DATA_W-1:0] weight = '0;
    logic signed [DATA_W-1:0] ell_factor = '0;
    logic [COMP_W-1:0] component = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [DATA_W-1:0] binned_value;
    logic [EFF_W-1:0] effective_ell;
    logic bad_weight;
    logic saturated;

    power_spectrum_band_binner_top uut (.*);

    always #1 clk = ~clk;

    // predicted result of one request
    typedef struct packed {
        logic [31:0] binned;
        logic [27:0] eff;
        logic        bad;
        logic        sat;
    } band_result_t;

    // predictor state
    logic [11:0] p_ell_max;
    logic [2:0]  p_nspec;
    bit          p_assigned [N_ELL];
    logic [7:0]  p_band_of [N_ELL];
    logic signed [31:0] p_weight [N_ELL];
    logic signed [31:0] p_factor [N_ELL];
    logic signed [47:0] p_wsum [N_BAND];
    logic signed [47:0] p_esum [N_BAND];
    logic signed [63:0] p_acc [N_BAND*N_SPEC];

    band_result_t pending_results[$];
    int  error_count = 0;
    bit  hold_output = 1'b0;
    int  load_ells[$];

    // floor of x / 2^16
    function automatic logic signed [127:0] floor16(logic signed [127:0] x);
        return x >>> 16;
    endfunction

    // floor(mag*2^16/den) capped
    function automatic logic [63:0] scaled_quot(logic [63:0] mag, logic [63:0] den,
                                                logic [63:0] cap, ref bit sat);
        logic [127:0] q;
        q = ({64'd0, mag} << 16) / {64'd0, den};
        if (q > {64'd0, cap})
        begin
            sat = 1'b1;
            return cap;
        end
        return q[63:0];
    endfunction

    function automatic void clear_predictor();
        for (int i = 0; i < N_ELL; i++)
        begin
            p_assigned[i] = 1'b0;
            p_band_of[i] = '0;
            p_weight[i] = '0;
            p_factor[i] = '0;
        end
        for (int i = 0; i < N_BAND; i++)
        begin
            p_wsum[i] = '0;
            p_esum[i] = '0;
        end
        for (int i = 0; i < N_BAND*N_SPEC; i++)
            p_acc[i] = '0;
    endfunction

    // bin one request and return its predicted result
    function automatic band_result_t bin_request(logic [1:0] k, logic [11:0] e,
            logic signed [8:0] b, logic signed [31:0] w, logic signed [31:0] f,
            logic [1:0] c, logic signed [31:0] v);
        band_result_t r;
        bit sat;
        int ns;
        logic signed [127:0] wide;
        logic signed [127:0] wf;
        logic signed [127:0] term;
        logic signed [47:0] ws;
        logic signed [47:0] es;
        logic signed [63:0] acc;
        logic [63:0] q;
        r = '0;
        sat = 1'b0;
        ns = (p_nspec < 1) ? 1 : ((p_nspec > N_SPEC) ? N_SPEC : p_nspec);
        case (op_t'(k))
            OP_LOAD:
            begin
                if (e <= p_ell_max && b >= 0 && !p_assigned[e])
                begin
                    p_assigned[e] = 1'b1;
                    p_band_of[e] = b[7:0];
                    p_weight[e] = w;
                    p_factor[e] = (f <= 0) ? ONE_Q16 : f;
                    wide = 128'(p_wsum[b[7:0]]) + 128'(w);
                    if (wide > 128'(S48_HI)) begin wide = 128'(S48_HI); sat = 1'b1; end
                    if (wide < 128'(S48_LO)) begin wide = 128'(S48_LO); sat = 1'b1; end
                    p_wsum[b[7:0]] = wide[47:0];
                    wide = 128'(p_esum[b[7:0]]) + 128'($signed({1'b0, e})) * 128'(w);
                    if (wide > 128'(S48_HI)) begin wide = 128'(S48_HI); sat = 1'b1; end
                    if (wide < 128'(S48_LO)) begin wide = 128'(S48_LO); sat = 1'b1; end
                    p_esum[b[7:0]] = wide[47:0];
                end
            end
            OP_SAMPLE:
            begin
                if (p_assigned[e] && c < ns)
                begin
                    wf = floor16(128'(p_weight[e]) * 128'(p_factor[e]));
                    if (wf > 128'sh7FFF_FFFF) begin wf = 128'sh7FFF_FFFF; sat = 1'b1; end
                    if (wf < -128'sh8000_0000) begin wf = -128'sh8000_0000; sat = 1'b1; end
                    term = floor16(wf * 128'(v));
                    wide = 128'(p_acc[p_band_of[e]*N_SPEC + c]) + term;
                    if (wide > 128'sh7FFF_FFFF_FFFF_FFFF)
                    begin
                        wide = 128'sh7FFF_FFFF_FFFF_FFFF;
                        sat = 1'b1;
                    end
                    if (wide < -128'sh8000_0000_0000_0000)
                    begin
                        wide = -128'sh8000_0000_0000_0000;
                        sat = 1'b1;
                    end
                    p_acc[p_band_of[e]*N_SPEC + c] = wide[63:0];
                end
            end
            OP_READ:
            begin
                ws = (b >= 0) ? p_wsum[b[7:0]] : '0;
                if (ws <= 0)
                    r.bad = 1'b1;
                else
                begin
                    es = p_esum[b[7:0]];
                    if (c < ns)
                    begin
                        acc = p_acc[b[7:0]*N_SPEC + c];
                        if (acc >= 0)
                            q = scaled_quot(acc, 64'(ws), 64'h7FFF_FFFF, sat);
                        else
                        begin
                            q = scaled_quot(64'd0 - acc, 64'(ws), 64'h8000_0000, sat);
                            q = 64'd0 - q;
                        end
                        r.binned = q[31:0];
                    end
                    if (es < 0)
                        sat = 1'b1;
                    else
                    begin
                        q = scaled_quot(64'(es), 64'(ws), 64'h0FFF_FFFF, sat);
                        r.eff = q[27:0];
                    end
                end
            end
            default: clear_predictor();
        endcase
        r.sat = sat;
        return r;
    endfunction

    // send one request, predict at acceptance
    task automatic send_request(logic [1:0] k, logic [11:0] e, logic signed [8:0] b,
            logic signed [31:0] w, logic signed [31:0] f, logic [1:0] c,
            logic signed [31:0] v);
        in_valid <= 1'b1;
        kind <= k;
        ell <= e;
        band <= b;
        weight <= w;
        ell_factor <= f;
        component <= c;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(bin_request(k, e, b, w, f, c, v));
    endtask

    // burst pacing: drop valid for a random gap now and then
    int burst_left = 0;
    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 20);
        if ($urandom_range(0, 3) != 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_ELL_MAX)
            p_ell_max = data;
        else
            p_nspec = data[2:0];
    endtask

    function automatic logic signed [31:0] rnd32();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(0, 32'h0004_0000));
            3: return -$signed($urandom_range(0, 32'h0004_0000));
            default: return $signed($urandom());
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        band_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result binned %h", $time, binned_value);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (binned_value !== want.binned)
                begin
                    $display("%0t binned_value exp %h got %h", $time, want.binned,
                             binned_value);
                    error_count++;
                end
                if (effective_ell !== want.eff)
                begin
                    $display("%0t effective_ell exp %h got %h", $time, want.eff,
                             effective_ell);
                    error_count++;
                end
                if (bad_weight !== want.bad)
                begin
                    $display("%0t bad_weight exp %b got %b", $time, want.bad, bad_weight);
                    error_count++;
                end
                if (saturated !== want.sat)
                begin
                    $display("%0t saturated exp %b got %b", $time, want.sat, saturated);
                    error_count++;
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_output)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 7) < 2)
            out_stall <= ($urandom_range(0, 1) == 1);
        else
            out_stall <= 1'b0;
    end

    task automatic test_directed();
        send_request(OP_READ, 0, 0, 0, 0, 0, 0);
        send_request(OP_LOAD, 0, 0, 32'sh0001_0000, 32'sh0002_0000, 0, 0);
        send_request(OP_LOAD, 12'd4095, 9'sd255, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0);
        send_request(OP_LOAD, 12'd5, -9'sd1, 32'sh0001_0000, 0, 0, 0);
        send_request(OP_LOAD, 0, 9'sd3, 32'sh0001_0000, 0, 0, 0);
        send_request(OP_LOAD, 12'd7, 0, 32'sh0003_0000, 32'sh8000_0000, 3, 0);
        send_request(OP_LOAD, 12'd9, 9'sd1, 32'sh8000_0000, 0, 0, 0);
        send_request(OP_SAMPLE, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF);
        send_request(OP_SAMPLE, 12'd7, 0, 0, 0, 0, 32'sh8000_0000);
        send_request(OP_SAMPLE, 12'd4095, 0, 0, 0, 0, 32'sh7FFF_FFFF);
        send_request(OP_SAMPLE, 12'd4095, 0, 0, 0, 0, 32'sh7FFF_FFFF);
        send_request(OP_SAMPLE, 12'd100, 0, 0, 0, 0, 32'sh0001_0000);
        send_request(OP_SAMPLE, 12'd7, 0, 0, 0, 2'd3, 32'sh0001_0000);
        send_request(OP_READ, 0, 0, 0, 0, 0, 0);
        send_request(OP_READ, 0, 0, 0, 0, 2'd3, 0);
        send_request(OP_READ, 0, 9'sd255, 0, 0, 0, 0);
        send_request(OP_READ, 0, 9'sd1, 0, 0, 0, 0);
        send_request(OP_READ, 0, -9'sd1, 0, 0, 0, 0);
        send_request(OP_CLEAR, 12'hFFF, 9'sd255, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 2'd3,
                     32'shFFFF_FFFF);
        send_request(OP_READ, 0, 0, 0, 0, 0, 0);
        drain();
    endtask

    // mostly load, sample, read on a few bands with random content
    task automatic test_random(int count, int ell_hi);
        int k;
        logic [11:0] e;
        logic signed [8:0] b;
        load_ells = {};
        for (int i = 0; i < count; i++)
        begin
            pace();
            k = $urandom_range(0, 99);
            b = (k % 17 == 0) ? -9'sd1 : 9'($urandom_range(0, 7));
            if ($urandom_range(0, 15) == 0)
                b = 9'($urandom_range(0, 255));
            if (k < 30)
            begin
                e = $urandom_range(0, ell_hi);
                if ($urandom_range(0, 30) == 0) e = $urandom_range(0, 4095);
                send_request(OP_LOAD, e, b, rnd32(), rnd32(), $urandom(), $urandom());
                load_ells.push_back(e);
            end
            else if (k < 75)
            begin
                e = (load_ells.size() > 0 && $urandom_range(0, 5) != 0)
                    ? load_ells[$urandom_range(0, load_ells.size() - 1)]
                    : $urandom_range(0, 4095);
                send_request(OP_SAMPLE, e, $urandom(), $urandom(), $urandom(),
                             $urandom(), rnd32());
            end
            else if (k < 99)
                send_request(OP_READ, $urandom(), b, $urandom(), $urandom(),
                             $urandom(), $urandom());
            else
            begin
                send_request(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom());
                load_ells = {};
            end
        end
        drain();
    endtask

    // hold the output long enough that the input queue fills up
    task automatic test_backpressure();
        fork
            begin
                hold_output = 1'b1;
                for (int n = 0; n < 300; n++)
                    @(posedge clk);
                hold_output = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_request(OP_READ, 0, 9'($urandom_range(0, 7)), 0, 0, $urandom(), 0);
        join
        drain();
    endtask

    initial
    begin
        p_ell_max = ELL_MAX_RST;
        p_nspec = NSPEC_RST;
        clear_predictor();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        write_reg(REG_NUM_SPECTRA, 12'd4);
        write_reg(REG_ELL_MAX, 12'd40);
        test_random(300, 63);
        test_backpressure();
        write_reg(REG_NUM_SPECTRA, 12'd2);
        write_reg(REG_ELL_MAX, 12'd0);
        test_random(100, 15);
        write_reg(REG_NUM_SPECTRA, 12'd7);
        write_reg(REG_ELL_MAX, 12'd4095);
        test_random(300, 200);
        write_reg(REG_NUM_SPECTRA, 12'd0);
        test_random(150, 63);
        write_reg(REG_NUM_SPECTRA, 12'd3);
        test_random(180, 4095);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[power_spectrum_band_binner_top.f]
hdl/psbb_pkg.sv
hdl/psbb_front.sv
hdl/psbb_div.sv
hdl/psbb_back.sv
hdl/power_spectrum_band_binner_top.sv
test/tb_power_spectrum_band_binner_top.sv
